@@ hdl/lz_growing_offset_decoder_macros.svh @@
// Assertion helpers shared by the decoder's RTL.
`ifndef LZ_GROWING_OFFSET_DECODER_MACROS_SVH
`define LZ_GROWING_OFFSET_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LZGO_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define LZGO_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hdl/lzgo_pkg.sv @@
package lzgo_pkg;

    localparam int HISTORY_DEPTH = 65536;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

    localparam int OC_W  = 17;
    localparam int RAW_W = 16;
    localparam int PW_W  = 5;
    localparam int RES_W = 24;
    localparam int CNT_W = 5;
    localparam int POS_W = 16;

    localparam logic [PW_W-1:0]  PW_INIT    = 5'd8;
    localparam logic [PW_W-1:0]  PW_MAX     = 5'd16;
    localparam logic [CNT_W-1:0] MATCH_BIAS = 5'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BAD   = 2'd1;
    localparam logic [1:0] STATUS_TRUNC = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PARSE,
        ST_COPY,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_LIT,
        PH_POS,
        PH_CNT
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       done;
        logic [1:0] status;
    } result_t;

endpackage

@@ hdl/lzgo_ram.sv @@
module lzgo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/lz_growing_offset_decoder.sv @@
// LZ77 decoder with absolute match positions and a growing position field. Each input
// beat carries one packed byte (header already removed); tokens are decoded MSB first
// from a 24-bit bit reservoir and every decoded byte is written into a history RAM
// and sent on the output stream, with tlast on the last byte caused by that input beat.
// An input beat occupies the block while it is accepted, then for each token field
// (flag, literal, position, count), each step of position-width growth, each copied
// byte and the closing of the beat; no new beat is taken until it returns to idle.
// Match copies stream at one byte per cycle through the single-port-read history RAM,
// with write-to-read forwarding for overlapping copies, and stall while the output
// register is held by the sink. After completion or an error every further input
// beat is taken and ignored.
`include "lz_growing_offset_decoder_macros.svh"

module lz_growing_offset_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // raw_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // packed_byte
    input  logic        s_tlast,       // input_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // out_byte
    output logic        m_tlast,       // run_last
    output logic [2:0]  m_tuser        // [0] stream_done, [2:1] status
);

    localparam int AW = lzgo_pkg::HIST_AW;

    lzgo_pkg::state_t                 state_reg, state_next;
    lzgo_pkg::phase_t                 phase_reg, phase_next;
    logic [lzgo_pkg::RES_W-1:0]       res_reg, res_next;
    logic [lzgo_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [lzgo_pkg::OC_W-1:0]        oc_reg, oc_next;
    logic [lzgo_pkg::PW_W-1:0]        pw_reg, pw_next;
    logic [lzgo_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                             halted_reg, halted_next;
    logic                             last_reg, last_next;
    logic [lzgo_pkg::RAW_W-1:0]       raw_size_reg;
    logic [lzgo_pkg::CNT_W-1:0]       rem_reg, rem_next;
    logic [AW-1:0]                    rd_addr_reg, rd_addr_next;
    logic                             fwd_reg, fwd_next;
    logic [7:0]                       fwd_data_reg, fwd_data_next;
    logic                             stage_valid_reg, stage_valid_next;
    lzgo_pkg::result_t                stage_reg, stage_next;
    logic                             out_valid_reg, out_valid_next;
    lzgo_pkg::result_t                out_reg, out_next;
    logic                             out_last_reg, out_last_next;

    // History RAM ports
    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic [7:0]                       ram_wdata;
    logic                             ram_re;
    logic [AW-1:0]                    ram_raddr;
    logic [7:0]                       ram_rdata;

    // Datapath terms
    logic [lzgo_pkg::CNT_W-1:0]       take_n;
    logic                             have_bits;
    logic [lzgo_pkg::RES_W-1:0]       res_sh;
    logic [lzgo_pkg::POS_W-1:0]       field;
    logic                             can_grow;
    logic [lzgo_pkg::CNT_W-1:0]       match_len;
    logic [lzgo_pkg::OC_W-1:0]        oc_inc;
    logic                             done_flag;
    logic                             lit_over;
    logic                             match_bad;
    logic [7:0]                       copy_data;
    logic                             out_free;
    logic                             in_accept;
    logic                             parse_wait;
    logic                             parse_end;
    logic                             parse_copy;
    logic                             fin_need;
    logic                             push_en;
    lzgo_pkg::result_t                push_val;
    logic                             fin_load;
    lzgo_pkg::result_t                fin_val;

    lzgo_ram #(
        .WIDTH (8),
        .DEPTH (lzgo_pkg::HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == lzgo_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_reg.status, out_reg.done};

    // Bit extraction and the checks made on each token step.
    always_comb
    begin
        case (phase_reg)
            lzgo_pkg::PH_FLAG: take_n = 5'd1;
            lzgo_pkg::PH_LIT:  take_n = 5'd8;
            lzgo_pkg::PH_POS:  take_n = pw_reg;
            default:           take_n = 5'd4;
        endcase
        have_bits = (cnt_reg >= take_n);
        res_sh    = res_reg >> (cnt_reg - take_n);
        field     = res_sh[lzgo_pkg::POS_W-1:0]
                    & lzgo_pkg::POS_W'((17'd1 << take_n) - 17'd1);
        can_grow  = (pw_reg < lzgo_pkg::PW_MAX) && (oc_reg > (17'd1 << pw_reg));
        match_len = {1'b0, field[3:0]} + lzgo_pkg::MATCH_BIAS;
        oc_inc    = oc_reg + 17'd1;
        done_flag = (oc_inc == {1'b0, raw_size_reg});
        lit_over  = (oc_reg >= {1'b0, raw_size_reg});
        match_bad = ({1'b0, pos_reg} >= oc_reg)
                    || ((18'(oc_reg) + 18'(match_len)) > 18'(raw_size_reg));
        copy_data = fwd_reg ? fwd_data_reg : ram_rdata;
        fin_need  = stage_valid_reg || (last_reg && !halted_reg);

        // A step that produces a result waits for room in the output register.
        parse_wait = !out_free && have_bits
                     && ((phase_reg == lzgo_pkg::PH_LIT)
                         || ((phase_reg == lzgo_pkg::PH_CNT) && match_bad));
        parse_end  = !parse_wait
                     && ((!have_bits && !((phase_reg == lzgo_pkg::PH_POS) && can_grow))
                         || ((phase_reg == lzgo_pkg::PH_LIT) && have_bits
                             && (lit_over || done_flag))
                         || ((phase_reg == lzgo_pkg::PH_CNT) && have_bits && match_bad));
        parse_copy = (phase_reg == lzgo_pkg::PH_CNT) && have_bits && !match_bad;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzgo_pkg::ST_IDLE:
            begin
                if (in_accept && !halted_reg)
                begin
                    state_next = lzgo_pkg::ST_PARSE;
                end
            end
            lzgo_pkg::ST_PARSE:
            begin
                if (parse_end)
                begin
                    state_next = lzgo_pkg::ST_FINISH;
                end
                else if (parse_copy)
                begin
                    state_next = lzgo_pkg::ST_COPY;
                end
            end
            lzgo_pkg::ST_COPY:
            begin
                if (out_free && (rem_reg == 5'd1))
                begin
                    state_next = done_flag ? lzgo_pkg::ST_FINISH : lzgo_pkg::ST_PARSE;
                end
            end
            lzgo_pkg::ST_FINISH:
            begin
                if (!fin_need || out_free)
                begin
                    state_next = lzgo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lzgo_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        phase_next       = phase_reg;
        res_next         = res_reg;
        cnt_next         = cnt_reg;
        oc_next          = oc_reg;
        pw_next          = pw_reg;
        pos_next         = pos_reg;
        halted_next      = halted_reg;
        last_next        = last_reg;
        rem_next         = rem_reg;
        rd_addr_next     = rd_addr_reg;
        fwd_next         = fwd_reg;
        fwd_data_next    = fwd_data_reg;
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_next         = out_reg;
        out_last_next    = out_last_reg;
        ram_we           = 1'b0;
        ram_waddr        = oc_reg[AW-1:0];
        ram_wdata        = field[7:0];
        ram_re           = 1'b0;
        ram_raddr        = pos_reg[AW-1:0];
        push_en          = 1'b0;
        push_val         = '{data: field[7:0], done: done_flag, status: lzgo_pkg::STATUS_OK};
        fin_load         = 1'b0;
        fin_val          = stage_reg;

        unique case (state_reg)
            lzgo_pkg::ST_IDLE:
            begin
                if (in_accept && !halted_reg)
                begin
                    res_next  = {res_reg[lzgo_pkg::RES_W-9:0], s_tdata};
                    cnt_next  = cnt_reg + 5'd8;
                    last_next = s_tlast;
                end
            end
            lzgo_pkg::ST_PARSE:
            begin
                case (phase_reg)
                    lzgo_pkg::PH_FLAG:
                    begin
                        if (have_bits)
                        begin
                            cnt_next   = cnt_reg - take_n;
                            phase_next = field[0] ? lzgo_pkg::PH_LIT : lzgo_pkg::PH_POS;
                        end
                    end
                    lzgo_pkg::PH_LIT:
                    begin
                        if (have_bits && out_free)
                        begin
                            cnt_next = cnt_reg - take_n;
                            push_en  = 1'b1;
                            if (lit_over)
                            begin
                                push_val    = '{data: 8'd0, done: 1'b0,
                                                status: lzgo_pkg::STATUS_BAD};
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                oc_next     = oc_inc;
                                phase_next  = lzgo_pkg::PH_FLAG;
                                halted_next = done_flag;
                            end
                        end
                    end
                    lzgo_pkg::PH_POS:
                    begin
                        // The width grows one bit per cycle before the field is taken.
                        if (can_grow)
                        begin
                            pw_next = pw_reg + 5'd1;
                        end
                        else if (have_bits)
                        begin
                            cnt_next   = cnt_reg - take_n;
                            pos_next   = field;
                            phase_next = lzgo_pkg::PH_CNT;
                        end
                    end
                    default:
                    begin
                        if (have_bits)
                        begin
                            if (match_bad)
                            begin
                                if (out_free)
                                begin
                                    cnt_next    = cnt_reg - take_n;
                                    push_en     = 1'b1;
                                    push_val    = '{data: 8'd0, done: 1'b0,
                                                    status: lzgo_pkg::STATUS_BAD};
                                    halted_next = 1'b1;
                                end
                            end
                            else
                            begin
                                cnt_next     = cnt_reg - take_n;
                                rem_next     = match_len;
                                ram_re       = 1'b1;
                                ram_raddr    = pos_reg[AW-1:0];
                                rd_addr_next = pos_reg[AW-1:0];
                                fwd_next     = 1'b0;
                                phase_next   = lzgo_pkg::PH_FLAG;
                            end
                        end
                    end
                endcase
            end
            lzgo_pkg::ST_COPY:
            begin
                if (out_free)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = copy_data;
                    oc_next   = oc_inc;
                    rem_next  = rem_reg - 5'd1;
                    push_en   = 1'b1;
                    push_val  = '{data: copy_data, done: done_flag,
                                  status: lzgo_pkg::STATUS_OK};
                    if (rem_reg != 5'd1)
                    begin
                        // A read of the entry written in this cycle takes the new byte.
                        ram_re        = 1'b1;
                        ram_raddr     = rd_addr_reg + AW'(1);
                        rd_addr_next  = rd_addr_reg + AW'(1);
                        fwd_next      = (ram_raddr == ram_waddr);
                        fwd_data_next = copy_data;
                    end
                    else
                    begin
                        halted_next = done_flag;
                    end
                end
            end
            lzgo_pkg::ST_FINISH:
            begin
                if (!fin_need || out_free)
                begin
                    fin_load         = fin_need;
                    stage_valid_next = 1'b0;
                    if (!stage_valid_reg)
                    begin
                        fin_val = '{data: 8'd0, done: 1'b0, status: lzgo_pkg::STATUS_OK};
                    end
                    if (last_reg && !halted_reg)
                    begin
                        fin_val.status = lzgo_pkg::STATUS_TRUNC;
                    end
                    halted_next = halted_reg || last_reg;
                end
            end
            default:
            begin
            end
        endcase

        // One result is held back so that the last one of a beat can carry tlast.
        if (push_en)
        begin
            stage_valid_next = 1'b1;
            stage_next       = push_val;
            if (stage_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = stage_reg;
                out_last_next  = 1'b0;
            end
        end
        if (fin_load)
        begin
            out_valid_next = 1'b1;
            out_next       = fin_val;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lzgo_pkg::ST_IDLE;
            phase_reg       <= lzgo_pkg::PH_FLAG;
            res_reg         <= '0;
            cnt_reg         <= '0;
            oc_reg          <= '0;
            pw_reg          <= lzgo_pkg::PW_INIT;
            pos_reg         <= '0;
            halted_reg      <= 1'b0;
            last_reg        <= 1'b0;
            raw_size_reg    <= 16'd1;
            rem_reg         <= '0;
            fwd_reg         <= 1'b0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            res_reg         <= res_next;
            cnt_reg         <= cnt_next;
            oc_reg          <= oc_next;
            pw_reg          <= pw_next;
            pos_reg         <= pos_next;
            halted_reg      <= halted_next;
            last_reg        <= last_next;
            rem_reg         <= rem_next;
            fwd_reg         <= fwd_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                raw_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        fwd_data_reg <= fwd_data_next;
        stage_reg    <= stage_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    `LZGO_ASSERT_NOW(a_copy_active, (state_reg == lzgo_pkg::ST_COPY), ((rem_reg != 5'd0) && !halted_reg), "copy running with no bytes left or after halt")
    `LZGO_ASSERT_NEXT(a_halted_ignores, (in_accept && halted_reg), ((state_reg == lzgo_pkg::ST_IDLE) && !stage_valid_reg), "beat after halt was not ignored")
    `LZGO_ASSERT_NEXT(a_forward_same_entry, (ram_re && ram_we && (ram_raddr == ram_waddr)), fwd_reg, "read of entry being written is not forwarded")

endmodule
